FILE: sv/gww_pkg.sv
`timescale 1ns / 1ps

package gww_pkg;

  // line table depth; breaks stop once the line count reaches it
  localparam int unsigned LineTableSize = 4096;

  localparam int unsigned PosW   = 16;
  localparam int unsigned ColW   = 8;
  localparam int unsigned LinesW = 13;
  localparam int unsigned IndexW = 12;
  localparam int unsigned WordsW = 16;

  localparam logic [LinesW-1:0] LineLimit = LinesW'(LineTableSize);
  localparam logic [WordsW-1:0] WordMax   = {WordsW{1'b1}};
  localparam logic [ColW-1:0]   CplReset  = 8'd40;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef struct packed {
    logic [PosW-1:0]   position;
    logic [ColW-1:0]   column;
    logic              space_seen;
    logic [PosW-1:0]   space_offset;
    logic [PosW-1:0]   line_start;
    logic [LinesW-1:0] line_total;
    logic              inside_word;
    logic [WordsW-1:0] word_total;
  } scan_state_t;

  typedef struct packed {
    logic              break_valid;
    logic [IndexW-1:0] break_index;
    logic [PosW-1:0]   break_pos;
    logic [LinesW-1:0] lines_so_far;
    logic [WordsW-1:0] words_so_far;
    logic              end_of_text;
  } scan_result_t;

  localparam scan_state_t ScanReset = '{
    position:     '0,
    column:       '0,
    space_seen:   1'b0,
    space_offset: '0,
    line_start:   '0,
    line_total:   LinesW'(1),
    inside_word:  1'b0,
    word_total:   '0
  };

endpackage

FILE: sv/greedy_word_wrap_scanner.sv
`timescale 1ns / 1ps

// Greedy word-wrap scanner: text bytes stream in on the slave side, one per
// beat, with tlast on the final byte. Every byte gives one result beat that
// tells whether a new display line starts (tuser), where it starts, its line
// table index, and the running line and word counts; tlast on the result
// marks the counts as final, after which the scan state returns to reset
// while the wrap width is kept. One byte is taken every cycle while the
// result side accepts beats: a byte sits in an input register while the scan
// state and the byte feed a single step of compare, increment and subtract
// logic, whose result lands in the output register; the scan-state update
// loop passes through this single step and the state register. Once the line
// count hits the table size, breaks stop but words are still counted. The wrap
// width may be written only while no beat is in flight.
module greedy_word_wrap_scanner import gww_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // wrap width register
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // text input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch[7:0]
  input  logic        s_axis_tlast,   // last
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // break_index[11:0], break_pos[27:12],
                                      // lines_so_far[40:28], words_so_far[56:41]
  output logic        m_axis_tuser,   // break_valid
  output logic        m_axis_tlast    // end_of_text
);

  logic [ColW-1:0] cpl_q;

  // input register
  logic       in_valid_q;
  logic [7:0] in_ch_q;
  logic       in_last_q;

  // output register
  logic         out_valid_q;
  scan_result_t out_q;

  scan_state_t  state_q;
  scan_state_t  state_d;
  scan_result_t result_d;

  logic out_free;
  logic step_fire;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step_fire     = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpl_q <= CplReset;
    end else if (cfg_we_i) begin
      cpl_q <= cfg_wdata_i;
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q   <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  gww_step u_step (
    .state_i  (state_q),
    .ch_i     (in_ch_q),
    .last_i   (in_last_q),
    .cpl_i    (cpl_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // scan state advances with each processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ScanReset;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      out_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.words_so_far, out_q.lines_so_far,
                          out_q.break_pos, out_q.break_index};
  assign m_axis_tuser  = out_q.break_valid;
  assign m_axis_tlast  = out_q.end_of_text;

endmodule

FILE: sv/gww_step.sv
`timescale 1ns / 1ps

module gww_step import gww_pkg::*; (
  input  scan_state_t  state_i,
  input  logic [7:0]   ch_i,
  input  logic         last_i,
  input  logic [ColW-1:0] cpl_i,
  output scan_state_t  state_o,
  output scan_result_t result_o
);

  logic            active;
  logic            is_space;
  logic            is_sep;
  logic [PosW-1:0] next_pos;
  logic [ColW-1:0] col_inc;
  logic            seen_t;
  logic [PosW-1:0] offset_t;
  logic            brk;
  logic [PosW-1:0] brk_pos;
  scan_state_t     nxt;

  assign active   = state_i.line_total < LineLimit;
  assign is_space = ch_i == ChSpace;
  assign is_sep   = is_space || ch_i == ChLf || ch_i == ChTab || ch_i == ChCr;
  assign next_pos = state_i.position + PosW'(1);
  assign col_inc  = state_i.column + ColW'(1);
  assign seen_t   = state_i.space_seen | is_space;
  assign offset_t = is_space ? state_i.position : state_i.space_offset;

  always_comb begin
    nxt     = state_i;
    brk     = 1'b0;
    brk_pos = '0;
    if (active) begin
      if (ch_i == ChLf) begin
        brk            = 1'b1;
        brk_pos        = next_pos;
        nxt.column     = '0;
        nxt.space_seen = 1'b0;
      end else begin
        nxt.space_offset = offset_t;
        if (col_inc >= cpl_i) begin
          // wrap after the last usable space, else after this byte
          brk_pos = (seen_t && offset_t > state_i.line_start) ? offset_t + PosW'(1)
                                                               : next_pos;
          brk            = 1'b1;
          nxt.space_seen = 1'b0;
        end else begin
          nxt.space_seen = seen_t;
        end
      end
      if (brk) begin
        nxt.line_start = brk_pos;
        nxt.line_total = state_i.line_total + LinesW'(1);
      end
      nxt.position = next_pos;
    end

    if (active && ch_i != ChLf) begin
      nxt.column = brk ? ColW'(next_pos - brk_pos) : col_inc;
    end

    if (is_sep) begin
      nxt.inside_word = 1'b0;
    end else if (!state_i.inside_word) begin
      nxt.inside_word = 1'b1;
      if (state_i.word_total != WordMax) begin
        nxt.word_total = state_i.word_total + WordsW'(1);
      end
    end
  end

  always_comb begin
    result_o.break_valid  = brk;
    result_o.break_index  = brk ? state_i.line_total[IndexW-1:0] : '0;
    result_o.break_pos    = brk_pos;
    result_o.lines_so_far = nxt.line_total;
    result_o.words_so_far = nxt.word_total;
    result_o.end_of_text  = last_i;
  end

  assign state_o = last_i ? ScanReset : nxt;

endmodule
